/* rtl/core/assert_macros.svh */
// Assertion macros used by the top RTL file of the grid path search block.
// Each macro expects a clock named i_clk; GAPS_ASSERT also expects an active-low reset named i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define GAPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define GAPS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/core/gaps_pkg.sv */
// Types, constants and direction tables for the grid path search block.
// No dependencies.
`default_nettype none

package gaps_pkg;

    localparam int GRID_WIDTH_DEF  = 32;
    localparam int GRID_HEIGHT_DEF = 32;
    localparam int SKIP_COUNT_DEF  = 2;

    localparam int COST_W = 20;
    localparam logic [COST_W-1:0] COST_MAX      = 20'hFFFFF;
    localparam logic [8:0]        STEP_STRAIGHT = 9'd256;
    localparam logic [8:0]        STEP_DIAG     = 9'd362;

    localparam logic [1:0] MARK_NONE   = 2'd0;
    localparam logic [1:0] MARK_OPEN   = 2'd1;
    localparam logic [1:0] MARK_CLOSED = 2'd2;

    localparam logic [3:0] DIR_NONE = 4'd15;
    localparam logic [3:0] DIR_SELF = 4'd4;
    localparam logic [3:0] DIR_LAST = 4'd8;

    // Offset codes: column part is d/3, row part is d%3; 0 means +1, 1 none, 2 means -1
    localparam logic [1:0] OFS_PLUS  = 2'd0;
    localparam logic [1:0] OFS_ZERO  = 2'd1;
    localparam logic [1:0] OFS_MINUS = 2'd2;

    localparam logic [9:0] LIST_MAX = 10'd1023;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_RUN   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] REG_START_X = 2'd0;
    localparam logic [1:0] REG_START_Y = 2'd1;
    localparam logic [1:0] REG_GOAL_X  = 2'd2;
    localparam logic [1:0] REG_GOAL_Y  = 2'd3;

    typedef struct packed {
        logic [1:0] command;
        logic [4:0] cell_x;
        logic [4:0] cell_y;
        logic       blocked;
        logic [9:0] waypoint_index;
    } t_in_item;

    typedef struct packed {
        logic       found;
        logic [9:0] waypoint_count;
        logic [4:0] point_x;
        logic [4:0] point_y;
        logic       index_valid;
    } t_out_item;

    typedef struct packed {
        logic [1:0]        mark;
        logic [3:0]        dir;
        logic [COST_W-1:0] g;
        logic [COST_W-1:0] f;
    } t_node;

    function automatic logic [1:0] dir_col(input logic [3:0] d);
        logic [1:0] r;
        case (d)
            4'd0, 4'd1, 4'd2: r = OFS_PLUS;
            4'd6, 4'd7, 4'd8: r = OFS_MINUS;
            default:          r = OFS_ZERO;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] dir_row(input logic [3:0] d);
        logic [1:0] r;
        case (d)
            4'd0, 4'd3, 4'd6: r = OFS_PLUS;
            4'd2, 4'd5, 4'd8: r = OFS_MINUS;
            default:          r = OFS_ZERO;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/gaps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gaps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

/* rtl/core/gaps_heur.sv */
// Euclidean heuristic unit: round(sqrt(dx*dx+dy*dy)*256), saturated to 20 bits.
// One shared multiplier for the squares, then one root bit per cycle. Uses gaps_pkg.
`default_nettype none

module gaps_heur
    import gaps_pkg::*;
#(
    parameter int MW = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [MW-1:0]     i_dx,
    input  wire logic [MW-1:0]     i_dy,
    output      logic              o_done,
    output      logic [COST_W-1:0] o_h
);

    localparam int VW = 2 * MW + 18;
    localparam int SW = 2 * MW + 1;

    localparam logic [1:0] H_IDLE  = 2'd0;
    localparam logic [1:0] H_SQY   = 2'd1;
    localparam logic [1:0] H_ROOT  = 2'd2;
    localparam logic [1:0] H_ROUND = 2'd3;

    logic [1:0]        r_st, n_st;
    logic [MW-1:0]     r_dy, n_dy;
    logic [SW-1:0]     r_acc, n_acc;
    logic [VW-1:0]     r_v, n_v;
    logic [VW-1:0]     r_r, n_r;
    logic [VW-1:0]     r_bit, n_bit;
    logic              r_done, n_done;
    logic [COST_W-1:0] r_h, n_h;

    logic [MW-1:0]   mul_a;
    logic [2*MW-1:0] mul_p;
    logic [VW-1:0]   trial;
    logic [VW-1:0]   rounded;

    assign mul_a   = (r_st == H_IDLE) ? i_dx : r_dy;
    assign mul_p   = mul_a * mul_a;
    assign trial   = r_r + r_bit;
    assign rounded = r_r + ((r_v > r_r) ? VW'(1) : VW'(0));

    always_comb begin
        n_st   = r_st;
        n_dy   = r_dy;
        n_acc  = r_acc;
        n_v    = r_v;
        n_r    = r_r;
        n_bit  = r_bit;
        n_done = 1'b0;
        n_h    = r_h;
        case (r_st)
            H_IDLE: begin
                if (i_start) begin
                    n_acc = SW'(mul_p);
                    n_dy  = i_dy;
                    n_st  = H_SQY;
                end
            end
            H_SQY: begin
                n_v   = VW'(r_acc + SW'(mul_p)) << 16;
                n_r   = '0;
                n_bit = VW'(1) << (VW - 2);
                n_st  = H_ROOT;
            end
            H_ROOT: begin
                if (r_bit == '0) begin
                    n_st = H_ROUND;
                end else begin
                    if (r_v >= trial) begin
                        n_v = r_v - trial;
                        n_r = (r_r >> 1) + r_bit;
                    end else begin
                        n_r = r_r >> 1;
                    end
                    n_bit = r_bit >> 2;
                end
            end
            H_ROUND: begin
                // r_v holds the remainder v - r*r here
                n_h    = (rounded > VW'(COST_MAX)) ? COST_MAX : rounded[COST_W-1:0];
                n_done = 1'b1;
                n_st   = H_IDLE;
            end
            default: n_st = H_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= H_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
        end
        r_dy  <= n_dy;
        r_acc <= n_acc;
        r_v   <= n_v;
        r_r   <= n_r;
        r_bit <= n_bit;
        r_h   <= n_h;
    end

    assign o_done = r_done;
    assign o_h    = r_h;

endmodule

`default_nettype wire

/* rtl/core/grid_a_star_path_search.sv */
// A run with both ends inside the grid clears the node state, then per expanded cell
// checks its eight neighbors, scans all cells for the open node of least f and starts
// the root unit per improved neighbor; walk back keeps every (SKIP_COUNT+1)-th cell.
// One item at a time; a result may wait in the output register while the next is taken.
// Reset: synchronous, active low; then a pass over all cells clears the obstacle map
// (no item accepted, configuration writes taken). Valid runs clear node state likewise.
`default_nettype none
`include "assert_macros.svh"

module grid_a_star_path_search
    import gaps_pkg::*;
#(
    parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
    parameter int SKIP_COUNT  = SKIP_COUNT_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output      logic      o_in_ready,
    input  wire t_in_item  i_in_item,
    output      logic      o_out_valid,
    input  wire logic      i_out_ready,
    output      t_out_item o_out_item,
    input  wire logic      psel,
    input  wire logic      penable,
    input  wire logic      pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = $clog2(GRID_WIDTH);
    localparam int YW    = $clog2(GRID_HEIGHT);
    localparam int MW    = (XW > YW) ? XW : YW;
    localparam int CW    = XW + YW;
    localparam int KW    = (SKIP_COUNT > 0) ? $clog2(SKIP_COUNT + 1) : 1;
    localparam int NW    = $bits(t_node);
    localparam int LD    = 1024;

    localparam logic [XW-1:0] X_LAST = XW'(GRID_WIDTH - 1);
    localparam logic [YW-1:0] Y_LAST = YW'(GRID_HEIGHT - 1);
    localparam logic [AW-1:0] A_LAST = AW'(CELLS - 1);

    localparam logic [4:0] ST_CLR_OBS  = 5'd0;
    localparam logic [4:0] ST_IDLE     = 5'd1;
    localparam logic [4:0] ST_RD_DATA  = 5'd2;
    localparam logic [4:0] ST_DONE     = 5'd3;
    localparam logic [4:0] ST_CLR_NODE = 5'd4;
    localparam logic [4:0] ST_START    = 5'd5;
    localparam logic [4:0] ST_NB       = 5'd6;
    localparam logic [4:0] ST_NB_RD    = 5'd7;
    localparam logic [4:0] ST_H_WAIT   = 5'd8;
    localparam logic [4:0] ST_SCAN     = 5'd9;
    localparam logic [4:0] ST_SCAN_END = 5'd10;
    localparam logic [4:0] ST_PICK     = 5'd11;
    localparam logic [4:0] ST_W_CHK    = 5'd12;
    localparam logic [4:0] ST_W_P1     = 5'd13;
    localparam logic [4:0] ST_W_SKIP   = 5'd14;
    localparam logic [4:0] ST_W_P2     = 5'd15;

    function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x, input logic [YW-1:0] y);
        return AW'(32'(y) * 32'(GRID_WIDTH) + 32'(x));
    endfunction

    // ---------------- configuration ----------------
    logic [4:0] r_sx, r_sy, r_gx, r_gy;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx <= '0;
            r_sy <= '0;
            r_gx <= '0;
            r_gy <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_START_X: r_sx <= pwdata[4:0];
                REG_START_Y: r_sy <= pwdata[4:0];
                REG_GOAL_X:  r_gx <= pwdata[4:0];
                REG_GOAL_Y:  r_gy <= pwdata[4:0];
                default:     r_sx <= r_sx;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_START_X: prdata = {27'd0, r_sx};
            REG_START_Y: prdata = {27'd0, r_sy};
            REG_GOAL_X:  prdata = {27'd0, r_gx};
            REG_GOAL_Y:  prdata = {27'd0, r_gy};
            default:     prdata = '0;
        endcase
    end

    // ---------------- state ----------------
    logic [4:0]        r_state, n_state;
    logic [AW-1:0]     r_ca, n_ca;
    logic              r_found, n_found;
    logic [9:0]        r_total, n_total;
    logic [XW-1:0]     r_cx, n_cx;
    logic [YW-1:0]     r_cy, n_cy;
    logic [COST_W-1:0] r_gcur, n_gcur;
    logic [3:0]        r_dir, n_dir;
    logic [XW-1:0]     r_nx, n_nx;
    logic [YW-1:0]     r_ny, n_ny;
    logic [COST_W-1:0] r_t, n_t;
    logic              r_fresh, n_fresh;
    logic [XW-1:0]     r_qx, n_qx;
    logic [YW-1:0]     r_qy, n_qy;
    logic              r_pv, n_pv;
    logic [XW-1:0]     r_px, n_px;
    logic [YW-1:0]     r_py, n_py;
    logic              r_bfound, n_bfound;
    logic [XW-1:0]     r_bx, n_bx;
    logic [YW-1:0]     r_by, n_by;
    t_node             r_bword, n_bword;
    logic [KW-1:0]     r_k, n_k;
    logic [4:0]        r_ptx, n_ptx;
    logic [4:0]        r_pty, n_pty;
    logic              r_ptv, n_ptv;
    logic              r_ov, n_ov;
    t_out_item         r_out, n_out;

    // ---------------- memories ----------------
    logic          obs_we, obs_wdata, obs_q;
    logic [AW-1:0] obs_waddr, obs_raddr;
    logic          node_we;
    logic [AW-1:0] node_waddr, node_raddr;
    t_node         node_wdata, node_q;
    logic [NW-1:0] node_qbits;
    logic          list_we;
    logic [9:0]    list_waddr;
    logic [CW-1:0] list_wdata, list_q;

    gaps_ram #(.WIDTH(1), .DEPTH(CELLS)) u_obs (
        .i_clk   (i_clk),
        .i_we    (obs_we),
        .i_waddr (obs_waddr),
        .i_wdata (obs_wdata),
        .i_raddr (obs_raddr),
        .o_rdata (obs_q)
    );

    gaps_ram #(.WIDTH(NW), .DEPTH(CELLS)) u_node (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_raddr (node_raddr),
        .o_rdata (node_qbits)
    );
    assign node_q = node_qbits;

    gaps_ram #(.WIDTH(CW), .DEPTH(LD)) u_list (
        .i_clk   (i_clk),
        .i_we    (list_we),
        .i_waddr (list_waddr),
        .i_wdata (list_wdata),
        .i_raddr (i_in_item.waypoint_index),
        .o_rdata (list_q)
    );

    // ---------------- heuristic unit ----------------
    logic              h_start, h_done;
    logic [MW-1:0]     h_dx, h_dy;
    logic [COST_W-1:0] h_val;

    gaps_heur #(.MW(MW)) u_heur (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (h_start),
        .i_dx    (h_dx),
        .i_dy    (h_dy),
        .o_done  (h_done),
        .o_h     (h_val)
    );

    // ---------------- datapath helpers ----------------
    logic [XW-1:0] sx, gx;
    logic [YW-1:0] sy, gy;
    logic          ends_ok;
    logic          in_accept;

    assign sx = XW'(r_sx);
    assign sy = YW'(r_sy);
    assign gx = XW'(r_gx);
    assign gy = YW'(r_gy);
    assign ends_ok = (32'(r_sx) < 32'(GRID_WIDTH)) && (32'(r_sy) < 32'(GRID_HEIGHT)) &&
                     (32'(r_gx) < 32'(GRID_WIDTH)) && (32'(r_gy) < 32'(GRID_HEIGHT));
    assign in_accept = i_in_valid & o_in_ready;

    // neighbor of the current cell in direction r_dir
    logic          nb_ok, nb_diag;
    logic [XW-1:0] nb_x;
    logic [YW-1:0] nb_y;

    always_comb begin
        nb_ok = (r_dir != DIR_SELF);
        nb_x  = r_cx;
        nb_y  = r_cy;
        case (dir_col(r_dir))
            OFS_PLUS:  if (r_cx == X_LAST) nb_ok = 1'b0; else nb_x = r_cx + XW'(1);
            OFS_MINUS: if (r_cx == '0) nb_ok = 1'b0; else nb_x = r_cx - XW'(1);
            default:   nb_x = r_cx;
        endcase
        case (dir_row(r_dir))
            OFS_PLUS:  if (r_cy == Y_LAST) nb_ok = 1'b0; else nb_y = r_cy + YW'(1);
            OFS_MINUS: if (r_cy == '0) nb_ok = 1'b0; else nb_y = r_cy - YW'(1);
            default:   nb_y = r_cy;
        endcase
        nb_diag = (dir_col(r_dir) != OFS_ZERO) && (dir_row(r_dir) != OFS_ZERO);
    end

    // parent of the current cell from the stored direction (opposite offset)
    logic          par_ok;
    logic [XW-1:0] par_x;
    logic [YW-1:0] par_y;

    always_comb begin
        par_ok = (node_q.dir <= DIR_LAST) && (node_q.dir != DIR_SELF);
        par_x  = r_cx;
        par_y  = r_cy;
        case (dir_col(node_q.dir))
            OFS_PLUS:  if (r_cx == '0) par_ok = 1'b0; else par_x = r_cx - XW'(1);
            OFS_MINUS: if (r_cx == X_LAST) par_ok = 1'b0; else par_x = r_cx + XW'(1);
            default:   par_x = r_cx;
        endcase
        case (dir_row(node_q.dir))
            OFS_PLUS:  if (r_cy == '0) par_ok = 1'b0; else par_y = r_cy - YW'(1);
            OFS_MINUS: if (r_cy == Y_LAST) par_ok = 1'b0; else par_y = r_cy + YW'(1);
            default:   par_y = r_cy;
        endcase
    end

    logic [COST_W:0]   t_sum, f_sum;
    logic [COST_W-1:0] t_sat, f_sat;
    logic              nb_take;

    assign t_sum = {1'b0, r_gcur} + (COST_W+1)'(nb_diag ? STEP_DIAG : STEP_STRAIGHT);
    assign t_sat = (t_sum > (COST_W+1)'(COST_MAX)) ? COST_MAX : t_sum[COST_W-1:0];
    assign f_sum = {1'b0, r_t} + {1'b0, h_val};
    assign f_sat = (f_sum > (COST_W+1)'(COST_MAX)) ? COST_MAX : f_sum[COST_W-1:0];
    assign nb_take = !obs_q && (node_q.mark != MARK_CLOSED) &&
                     ((node_q.mark != MARK_OPEN) || (t_sat < node_q.g));

    assign h_dx = MW'((r_nx > gx) ? (r_nx - gx) : (gx - r_nx));
    assign h_dy = MW'((r_ny > gy) ? (r_ny - gy) : (gy - r_ny));

    logic scan_hit;
    assign scan_hit = r_pv && (node_q.mark == MARK_OPEN) &&
                      (!r_bfound || (node_q.f < r_bword.f));

    // ---------------- sequencer ----------------
    always_comb begin
        n_state  = r_state;
        n_ca     = r_ca;
        n_found  = r_found;
        n_total  = r_total;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_gcur   = r_gcur;
        n_dir    = r_dir;
        n_nx     = r_nx;
        n_ny     = r_ny;
        n_t      = r_t;
        n_fresh  = r_fresh;
        n_qx     = r_qx;
        n_qy     = r_qy;
        n_pv     = r_pv;
        n_px     = r_px;
        n_py     = r_py;
        n_bfound = r_bfound;
        n_bx     = r_bx;
        n_by     = r_by;
        n_bword  = r_bword;
        n_k      = r_k;
        n_ptx    = r_ptx;
        n_pty    = r_pty;
        n_ptv    = r_ptv;
        n_ov     = r_ov && !i_out_ready;
        n_out    = r_out;

        obs_we     = 1'b0;
        obs_waddr  = r_ca;
        obs_wdata  = 1'b0;
        obs_raddr  = cell_addr(nb_x, nb_y);
        node_we    = 1'b0;
        node_waddr = r_ca;
        node_wdata = '{mark: MARK_NONE, dir: DIR_NONE, g: '0, f: '0};
        node_raddr = cell_addr(nb_x, nb_y);
        list_we    = 1'b0;
        list_waddr = r_total;
        list_wdata = {r_cy, r_cx};
        h_start    = 1'b0;

        case (r_state)
            ST_CLR_OBS: begin
                obs_we = 1'b1;
                n_ca   = r_ca + AW'(1);
                if (r_ca == A_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    n_ptx = '0;
                    n_pty = '0;
                    n_ptv = 1'b0;
                    n_state = ST_DONE;
                    case (i_in_item.command)
                        CMD_WRITE: begin
                            obs_waddr = cell_addr(XW'(i_in_item.cell_x), YW'(i_in_item.cell_y));
                            obs_wdata = i_in_item.blocked;
                            obs_we = (32'(i_in_item.cell_x) < 32'(GRID_WIDTH)) &&
                                     (32'(i_in_item.cell_y) < 32'(GRID_HEIGHT));
                        end
                        CMD_RUN: begin
                            n_found = 1'b0;
                            n_total = '0;
                            n_ca    = '0;
                            if (ends_ok) begin
                                n_state = ST_CLR_NODE;
                            end
                        end
                        CMD_READ: begin
                            if (i_in_item.waypoint_index < r_total) begin
                                n_state = ST_RD_DATA;
                            end
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_RD_DATA: begin
                n_ptx   = 5'(list_q[XW-1:0]);
                n_pty   = 5'(list_q[CW-1:XW]);
                n_ptv   = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_ov || i_out_ready) begin
                    n_ov    = 1'b1;
                    n_out   = '{found: r_found, waypoint_count: r_total, point_x: r_ptx,
                                point_y: r_pty, index_valid: r_ptv};
                    n_state = ST_IDLE;
                end
            end
            ST_CLR_NODE: begin
                node_we = 1'b1;
                n_ca    = r_ca + AW'(1);
                if (r_ca == A_LAST) begin
                    if (sx == gx && sy == gy) begin
                        n_found = 1'b1;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_START;
                    end
                end
            end
            ST_START: begin
                node_we    = 1'b1;
                node_waddr = cell_addr(sx, sy);
                node_wdata = '{mark: MARK_CLOSED, dir: DIR_NONE, g: '0, f: '0};
                n_cx    = sx;
                n_cy    = sy;
                n_gcur  = '0;
                n_dir   = DIR_LAST;
                n_state = ST_NB;
            end
            ST_NB: begin
                n_nx = nb_x;
                n_ny = nb_y;
                if (nb_ok) begin
                    n_state = ST_NB_RD;
                end else if (r_dir == '0) begin
                    n_qx = '0;
                    n_qy = '0;
                    n_pv = 1'b0;
                    n_bfound = 1'b0;
                    n_state = ST_SCAN;
                end else begin
                    n_dir = r_dir - 4'd1;
                end
            end
            ST_NB_RD: begin
                if (nb_take) begin
                    n_t     = t_sat;
                    n_fresh = (node_q.mark != MARK_OPEN);
                    h_start = 1'b1;
                    n_state = ST_H_WAIT;
                end else if (r_dir == '0) begin
                    n_qx = '0;
                    n_qy = '0;
                    n_pv = 1'b0;
                    n_bfound = 1'b0;
                    n_state = ST_SCAN;
                end else begin
                    n_dir   = r_dir - 4'd1;
                    n_state = ST_NB;
                end
            end
            ST_H_WAIT: begin
                if (h_done) begin
                    node_we    = 1'b1;
                    node_waddr = cell_addr(r_nx, r_ny);
                    node_wdata = '{mark: MARK_OPEN, dir: r_dir, g: r_t, f: f_sat};
                    if (r_fresh && r_nx == gx && r_ny == gy) begin
                        // goal reached: walk back from it
                        n_found = 1'b1;
                        n_cx    = gx;
                        n_cy    = gy;
                        n_state = ST_W_CHK;
                    end else if (r_dir == '0) begin
                        n_qx = '0;
                        n_qy = '0;
                        n_pv = 1'b0;
                        n_bfound = 1'b0;
                        n_state = ST_SCAN;
                    end else begin
                        n_dir   = r_dir - 4'd1;
                        n_state = ST_NB;
                    end
                end
            end
            ST_SCAN, ST_SCAN_END: begin
                node_raddr = cell_addr(r_qx, r_qy);
                if (scan_hit) begin
                    n_bfound = 1'b1;
                    n_bx     = r_px;
                    n_by     = r_py;
                    n_bword  = node_q;
                end
                n_px = r_qx;
                n_py = r_qy;
                if (r_state == ST_SCAN_END) begin
                    n_state = ST_PICK;
                end else begin
                    n_pv = 1'b1;
                    if (r_qx == X_LAST) begin
                        n_qx = '0;
                        n_qy = r_qy + YW'(1);
                        if (r_qy == Y_LAST) begin
                            n_state = ST_SCAN_END;
                        end
                    end else begin
                        n_qx = r_qx + XW'(1);
                    end
                end
            end
            ST_PICK: begin
                if (!r_bfound) begin
                    n_state = ST_DONE;
                end else begin
                    node_we    = 1'b1;
                    node_waddr = cell_addr(r_bx, r_by);
                    node_wdata = '{mark: MARK_CLOSED, dir: r_bword.dir, g: r_bword.g,
                                   f: r_bword.f};
                    n_cx    = r_bx;
                    n_cy    = r_by;
                    n_gcur  = r_bword.g;
                    n_dir   = DIR_LAST;
                    n_state = ST_NB;
                end
            end
            ST_W_CHK: begin
                node_raddr = cell_addr(r_cx, r_cy);
                if ((r_cx == sx && r_cy == sy) || r_total == LIST_MAX) begin
                    n_state = ST_DONE;
                end else begin
                    list_we = 1'b1;
                    n_total = r_total + 10'd1;
                    n_state = ST_W_P1;
                end
            end
            ST_W_P1: begin
                if (par_ok) begin
                    n_cx    = par_x;
                    n_cy    = par_y;
                    n_k     = '0;
                    n_state = ST_W_SKIP;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_W_SKIP: begin
                node_raddr = cell_addr(r_cx, r_cy);
                if (r_k == KW'(SKIP_COUNT)) begin
                    n_state = ST_W_CHK;
                end else begin
                    n_state = ST_W_P2;
                end
            end
            ST_W_P2: begin
                if (par_ok) begin
                    n_cx = par_x;
                    n_cy = par_y;
                end
                n_k     = r_k + KW'(1);
                n_state = ST_W_SKIP;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR_OBS;
            r_ca    <= '0;
            r_found <= 1'b0;
            r_total <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ca    <= n_ca;
            r_found <= n_found;
            r_total <= n_total;
            r_ov    <= n_ov;
        end
        r_cx     <= n_cx;
        r_cy     <= n_cy;
        r_gcur   <= n_gcur;
        r_dir    <= n_dir;
        r_nx     <= n_nx;
        r_ny     <= n_ny;
        r_t      <= n_t;
        r_fresh  <= n_fresh;
        r_qx     <= n_qx;
        r_qy     <= n_qy;
        r_pv     <= n_pv;
        r_px     <= n_px;
        r_py     <= n_py;
        r_bfound <= n_bfound;
        r_bx     <= n_bx;
        r_by     <= n_by;
        r_bword  <= n_bword;
        r_k      <= n_k;
        r_ptx    <= n_ptx;
        r_pty    <= n_pty;
        r_ptv    <= n_ptv;
        r_out    <= n_out;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    `GAPS_ASSERT(a_heur_done_expected, h_done |-> (r_state == ST_H_WAIT), "heuristic result unexpected")
    `GAPS_ASSERT(a_list_needs_found, (r_total != '0) |-> r_found, "waypoints without a found path")
    `GAPS_ASSERT(a_accept_leaves_idle, in_accept |=> (r_state != ST_IDLE), "accepted item not processed")
    `GAPS_ASSERT(a_pick_from_scan, (r_state == ST_PICK) |-> ($past(r_state) == ST_SCAN_END), "pick without scan")

endmodule

`default_nettype wire
